@@ rtl/core/iarc_pkg.sv @@
// Package for the IMU attitude and rate conditioner.
// Holds the shared widths, constants, register and function codes, types and helpers.
// No dependencies.
package iarc_pkg;

    // Fraction bits of the rate filter state (valid range 8 to 24)
    localparam int FILTER_FRAC_BITS = 16;

    localparam int ANGLE_W     = 14;
    localparam int ANGLE_OUT_W = 13;
    localparam int RATE_W      = 16;
    localparam int RATE_OUT_W  = 24;
    localparam int STATE_W     = 32;
    localparam int GAIN_W      = 17;
    localparam int DEADBAND_W  = 12;
    localparam int CFG_ADDR_W  = 1;
    localparam int CFG_DATA_W  = 17;
    localparam int OUT_FRAC_BITS = 8;

    localparam int ANGLE_CLAMP = 5760;
    localparam int HALF_TURN   = 2827;
    localparam int FULL_TURN   = 5655;
    localparam int GAIN_ONE    = 65536;
    localparam int ROUND_HALF  = 32768;
    localparam int GAIN_SHIFT  = 16;

    localparam logic [GAIN_W-1:0]     ALPHA_GAIN_RESET = GAIN_W'(6554);
    localparam logic [DEADBAND_W-1:0] DEADBAND_RESET   = DEADBAND_W'(45);

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_ALPHA_GAIN = 1'b0,
        CFG_DEADBAND   = 1'b1
    } iarc_cfg_addr_t;

    typedef enum logic {
        FUNC_LOCK   = 1'b0,
        FUNC_SAMPLE = 1'b1
    } iarc_func_t;

    typedef logic signed [ANGLE_W-1:0]     iarc_angle_t;
    typedef logic signed [ANGLE_OUT_W-1:0] iarc_angle_out_t;
    typedef logic signed [RATE_W-1:0]      iarc_rate_t;
    typedef logic signed [RATE_OUT_W-1:0]  iarc_rate_out_t;

    // Control shared by the three rate filter channels
    typedef struct packed {
        logic              update;
        logic [GAIN_W-1:0] gain;
    } iarc_filt_ctrl_t;

    function automatic iarc_angle_t clamp_angle(input iarc_angle_t raw);
        iarc_angle_t lim;
        lim = ANGLE_W'(ANGLE_CLAMP);
        if (raw > lim)
            return lim;
        else if (raw < -lim)
            return -lim;
        else
            return raw;
    endfunction

endpackage

@@ rtl/core/iarc_if.sv @@
// Handshake channels of the IMU attitude and rate conditioner: reading, result, config.
// Depends on iarc_pkg.
interface iarc_reading_if;
    logic                 valid;
    logic                 ready;
    logic                 func;
    iarc_pkg::iarc_angle_t imu_roll;
    iarc_pkg::iarc_angle_t imu_pitch;
    iarc_pkg::iarc_rate_t  raw_rate_x;
    iarc_pkg::iarc_rate_t  raw_rate_y;
    iarc_pkg::iarc_rate_t  raw_rate_z;

    modport source (output valid, func, imu_roll, imu_pitch, raw_rate_x, raw_rate_y,
                    raw_rate_z, input ready);
    modport sink (input valid, func, imu_roll, imu_pitch, raw_rate_x, raw_rate_y,
                  raw_rate_z, output ready);
endinterface

interface iarc_result_if;
    logic                      valid;
    logic                      ready;
    iarc_pkg::iarc_angle_out_t roll_angle;
    iarc_pkg::iarc_angle_out_t pitch_angle;
    iarc_pkg::iarc_rate_out_t  rate_x_filtered;
    iarc_pkg::iarc_rate_out_t  rate_y_filtered;
    iarc_pkg::iarc_rate_out_t  rate_z_filtered;

    modport source (output valid, roll_angle, pitch_angle, rate_x_filtered,
                    rate_y_filtered, rate_z_filtered, input ready);
    modport sink (input valid, roll_angle, pitch_angle, rate_x_filtered,
                  rate_y_filtered, rate_z_filtered, output ready);
endinterface

interface iarc_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [iarc_pkg::CFG_ADDR_W-1:0]     addr;
    logic [iarc_pkg::CFG_DATA_W-1:0]     data;

    modport source (output valid, addr, data, input ready);
    modport sink (input valid, addr, data, output ready);
endinterface

@@ rtl/core/iarc_angle.sv @@
// Relative angle unit: clamp, subtract reference, wrap to half a turn, apply deadband.
// Depends on iarc_pkg.
module iarc_angle (
    input  iarc_pkg::iarc_angle_t             raw,
    input  iarc_pkg::iarc_angle_t             reference,
    input  logic [iarc_pkg::DEADBAND_W-1:0]   deadband,
    output iarc_pkg::iarc_angle_out_t         angle
);
    import iarc_pkg::*;

    localparam int DW = ANGLE_W + 1;
    localparam logic signed [DW-1:0] HALF  = DW'(HALF_TURN);
    localparam logic signed [DW-1:0] FULL  = DW'(FULL_TURN);
    localparam logic signed [DW-1:0] FULL2 = DW'(2 * FULL_TURN);
    localparam logic signed [DW-1:0] EDGE2 = DW'(HALF_TURN + FULL_TURN);

    logic signed [DW-1:0]     diff;
    logic signed [DW-1:0]     wrapped;
    logic [DEADBAND_W-1:0]    mag;

    always_comb
    begin
        diff = DW'(clamp_angle(raw)) - DW'(reference);
        // after clamping, at most two turns need to be removed
        if (diff > EDGE2)
            wrapped = diff - FULL2;
        else if (diff > HALF)
            wrapped = diff - FULL;
        else if (diff < -EDGE2)
            wrapped = diff + FULL2;
        else if (diff < -HALF)
            wrapped = diff + FULL;
        else
            wrapped = diff;
        mag = wrapped[DW-1] ? DEADBAND_W'(-wrapped) : DEADBAND_W'(wrapped);
        if (mag < deadband)
            angle = '0;
        else
            angle = wrapped[ANGLE_OUT_W-1:0];
    end

endmodule

@@ rtl/core/iarc_rate_filter.sv @@
// One rate channel: first-order low-pass y += alpha*(x - y) with saturated state.
// Depends on iarc_pkg.
module iarc_rate_filter (
    input  logic                       clk,
    input  logic                       rst_n,
    input  iarc_pkg::iarc_filt_ctrl_t  ctrl,
    input  iarc_pkg::iarc_rate_t       rate,
    output iarc_pkg::iarc_rate_out_t   rate_filtered
);
    import iarc_pkg::*;

    localparam int XS_W   = RATE_W + FILTER_FRAC_BITS;
    localparam int DIFF_W = ((XS_W > STATE_W) ? XS_W : STATE_W) + 1;
    localparam int PROD_W = DIFF_W + GAIN_W + 1;
    localparam int SUM_W  = PROD_W + 1;
    localparam int OUT_SHIFT = FILTER_FRAC_BITS - OUT_FRAC_BITS;

    logic signed [STATE_W-1:0] y_reg;
    logic signed [STATE_W-1:0] y_next;

    logic [GAIN_W-1:0]          gain_sat;
    logic signed [GAIN_W:0]     gain_s;
    logic signed [DIFF_W-1:0]   x_scaled;
    logic signed [DIFF_W-1:0]   diff;
    logic signed [PROD_W-1:0]   prod;
    logic signed [PROD_W-1:0]   step;
    logic signed [SUM_W-1:0]    sum;
    logic signed [STATE_W-1:0]  shifted;

    always_comb
    begin
        gain_sat = (ctrl.gain > GAIN_W'(GAIN_ONE)) ? GAIN_W'(GAIN_ONE) : ctrl.gain;
        gain_s   = signed'({1'b0, gain_sat});
        x_scaled = DIFF_W'(rate) <<< FILTER_FRAC_BITS;
        diff     = x_scaled - DIFF_W'(y_reg);
        prod     = PROD_W'(gain_s) * PROD_W'(diff);
        // round half up, then floor shift
        step     = (prod + PROD_W'(ROUND_HALF)) >>> GAIN_SHIFT;
        sum      = SUM_W'(step) + SUM_W'(y_reg);
        if ((&sum[SUM_W-1:STATE_W-1]) || !(|sum[SUM_W-1:STATE_W-1]))
            y_next = sum[STATE_W-1:0];
        else if (sum[SUM_W-1])
            y_next = {1'b1, {(STATE_W-1){1'b0}}};
        else
            y_next = {1'b0, {(STATE_W-1){1'b1}}};

        shifted = y_next >>> OUT_SHIFT;
        if ((&shifted[STATE_W-1:RATE_OUT_W-1]) || !(|shifted[STATE_W-1:RATE_OUT_W-1]))
            rate_filtered = shifted[RATE_OUT_W-1:0];
        else if (shifted[STATE_W-1])
            rate_filtered = {1'b1, {(RATE_OUT_W-1){1'b0}}};
        else
            rate_filtered = {1'b0, {(RATE_OUT_W-1){1'b1}}};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            y_reg <= '0;
        else if (ctrl.update)
            y_reg <= y_next;
    end

endmodule

@@ rtl/core/imu_attitude_rate_conditioner_top.sv @@
// Top level of the IMU attitude and rate conditioner.
// Depends on iarc_pkg, the channel interfaces, iarc_angle and iarc_rate_filter.
//
// Takes one IMU reading per item and returns at most one result per item. A lock item
// (func 0) stores the clamped roll and pitch as references and returns nothing; a sample
// item (func 1) returns roll and pitch relative to those references, wrapped to half a
// turn and forced to zero inside the deadband, plus the three gyro rates through a
// first-order low-pass with gain alpha_gain (Q1.16, values above 1.0 act as 1.0).
// Each item waits in the input register and is finished in one pass of logic into the
// result register, so while the result side keeps up one item can be accepted every
// cycle; the filter state and references are updated as the item leaves the input
// register, so the next item always sees them. A sample item's result passes through the
// input register and then the result register before it is offered. The input side keeps
// taking items while a result waits; it stalls only when the input register holds a
// sample item and the result register holds a result that is not being taken.
// Configuration writes are always taken at once (register 0 alpha_gain, register 1
// deadband) and must only be made while no item is in flight.
module imu_attitude_rate_conditioner_top (
    input  logic                clk,
    input  logic                rst_n,
    iarc_cfg_if.sink            cfg,
    iarc_reading_if.sink        reading,
    iarc_result_if.source       result
);
    import iarc_pkg::*;

    // configuration registers
    logic [GAIN_W-1:0]     alpha_gain_reg;
    logic [DEADBAND_W-1:0] deadband_reg;

    // input register
    logic        s1_valid_reg;
    logic        s1_valid_next;
    logic        s1_func_reg;
    iarc_angle_t s1_roll_reg;
    iarc_angle_t s1_pitch_reg;
    iarc_rate_t  s1_rate_x_reg;
    iarc_rate_t  s1_rate_y_reg;
    iarc_rate_t  s1_rate_z_reg;

    // locked references
    iarc_angle_t roll_ref_reg;
    iarc_angle_t pitch_ref_reg;

    // result register
    logic            out_valid_reg;
    logic            out_valid_next;
    iarc_angle_out_t roll_angle_reg;
    iarc_angle_out_t pitch_angle_reg;
    iarc_rate_out_t  rate_x_reg;
    iarc_rate_out_t  rate_y_reg;
    iarc_rate_out_t  rate_z_reg;

    logic            in_accept;
    logic            s1_is_sample;
    logic            out_free;
    logic            s1_advance;
    logic            sample_fire;
    logic            lock_fire;
    iarc_filt_ctrl_t filt_ctrl;

    iarc_angle_out_t roll_angle_c;
    iarc_angle_out_t pitch_angle_c;
    iarc_rate_out_t  rate_x_c;
    iarc_rate_out_t  rate_y_c;
    iarc_rate_out_t  rate_z_c;

    // Handshake control: a lock item never waits for the result slot
    always_comb
    begin
        s1_is_sample = (s1_func_reg == FUNC_SAMPLE);
        out_free     = !out_valid_reg || result.ready;
        s1_advance   = s1_valid_reg && (!s1_is_sample || out_free);
        sample_fire  = s1_advance && s1_is_sample;
        lock_fire    = s1_advance && !s1_is_sample;
        in_accept    = reading.valid && reading.ready;

        s1_valid_next = in_accept || (s1_valid_reg && !s1_advance);

        if (sample_fire)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;

        filt_ctrl.update = sample_fire;
        filt_ctrl.gain   = alpha_gain_reg;
    end

    assign reading.ready = !s1_valid_reg || s1_advance;
    assign cfg.ready     = 1'b1;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_gain_reg <= ALPHA_GAIN_RESET;
            deadband_reg   <= DEADBAND_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.addr)
                CFG_ALPHA_GAIN: alpha_gain_reg <= cfg.data[GAIN_W-1:0];
                CFG_DEADBAND:   deadband_reg   <= cfg.data[DEADBAND_W-1:0];
                default:        ;
            endcase
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            roll_ref_reg  <= '0;
            pitch_ref_reg <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            // hold the clamped angles of a lock item as references
            if (lock_fire)
            begin
                roll_ref_reg  <= clamp_angle(s1_roll_reg);
                pitch_ref_reg <= clamp_angle(s1_pitch_reg);
            end
        end
    end

    // Input payload: load on acceptance
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_func_reg   <= reading.func;
            s1_roll_reg   <= reading.imu_roll;
            s1_pitch_reg  <= reading.imu_pitch;
            s1_rate_x_reg <= reading.raw_rate_x;
            s1_rate_y_reg <= reading.raw_rate_y;
            s1_rate_z_reg <= reading.raw_rate_z;
        end
    end

    iarc_angle u_roll (
        .raw       (s1_roll_reg),
        .reference (roll_ref_reg),
        .deadband  (deadband_reg),
        .angle     (roll_angle_c)
    );

    iarc_angle u_pitch (
        .raw       (s1_pitch_reg),
        .reference (pitch_ref_reg),
        .deadband  (deadband_reg),
        .angle     (pitch_angle_c)
    );

    iarc_rate_filter u_filt_x (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (filt_ctrl),
        .rate          (s1_rate_x_reg),
        .rate_filtered (rate_x_c)
    );

    iarc_rate_filter u_filt_y (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (filt_ctrl),
        .rate          (s1_rate_y_reg),
        .rate_filtered (rate_y_c)
    );

    iarc_rate_filter u_filt_z (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (filt_ctrl),
        .rate          (s1_rate_z_reg),
        .rate_filtered (rate_z_c)
    );

    // Result payload: capture when a sample item finishes
    always_ff @(posedge clk)
    begin
        if (sample_fire)
        begin
            roll_angle_reg  <= roll_angle_c;
            pitch_angle_reg <= pitch_angle_c;
            rate_x_reg      <= rate_x_c;
            rate_y_reg      <= rate_y_c;
            rate_z_reg      <= rate_z_c;
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.roll_angle      = roll_angle_reg;
    assign result.pitch_angle     = pitch_angle_reg;
    assign result.rate_x_filtered = rate_x_reg;
    assign result.rate_y_filtered = rate_y_reg;
    assign result.rate_z_filtered = rate_z_reg;

endmodule

@@ rtl/core/iarc_checker.sv @@
// Port-level checks for the IMU attitude and rate conditioner, bound to the top level.
// Depends on iarc_pkg and imu_attitude_rate_conditioner_top.
module iarc_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_ready,
    input logic                      in_func,
    input logic                      out_valid,
    input logic                      out_ready,
    input iarc_pkg::iarc_angle_out_t roll_angle,
    input iarc_pkg::iarc_angle_out_t pitch_angle
);
    import iarc_pkg::*;

    localparam logic signed [ANGLE_OUT_W-1:0] HALF = ANGLE_OUT_W'(HALF_TURN);

    // a stalled result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // the input side only stalls behind a blocked result
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled with result slot free");

    // after an accepted sample item, a result is offered once the item could have passed the input and result registers
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_func == FUNC_SAMPLE) |-> ##2 out_valid)
        else $error("sample item produced no result");

    // angles stay within half a turn
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (roll_angle <= HALF) && (roll_angle >= -HALF)
                   && (pitch_angle <= HALF) && (pitch_angle >= -HALF))
        else $error("angle outside half turn");

endmodule

bind imu_attitude_rate_conditioner_top iarc_checker u_iarc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (reading.valid),
    .in_ready    (reading.ready),
    .in_func     (reading.func),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .roll_angle  (result.roll_angle),
    .pitch_angle (result.pitch_angle)
);

@@ sim/imu_attitude_rate_conditioner_top_tb.sv @@
// Self-checking testbench for imu_attitude_rate_conditioner_top.
// Depends on iarc_pkg, the channel interfaces in iarc_if.sv and the RTL under rtl/core.
// Predicts each conditioned reading on acceptance and checks results in order.
module imu_attitude_rate_conditioner_top_tb;
    import iarc_pkg::*;

    // Cycles with no handshake on any channel before the run is abandoned
    localparam int WATCHDOG_LIMIT = 2000;
    // Cycles to let a trailing lock item leave the pipeline before a register write
    localparam int SETTLE_CYCLES  = 4;
    // Output stall used to fill the block and back up the reading channel
    localparam int LONG_HOLD      = 300;
    localparam int RANDOM_PHASES  = 12;
    localparam int PHASE_ITEMS    = 125;
    localparam int GAIN_MAX_CODE  = (1 << GAIN_W) - 1;
    localparam int DEADBAND_MAX   = (1 << DEADBAND_W) - 1;
    localparam int RATE_MAX       = (1 << (RATE_W - 1)) - 1;
    localparam int RATE_MIN       = -(1 << (RATE_W - 1));
    localparam int ANGLE_RAW_MAX  = (1 << (ANGLE_W - 1)) - 1;
    localparam int ANGLE_RAW_MIN  = -(1 << (ANGLE_W - 1));
    localparam longint STATE_MAX  = (longint'(1) << (STATE_W - 1)) - 1;
    localparam longint STATE_MIN  = -(longint'(1) << (STATE_W - 1));
    localparam longint OUT_MAX    = (longint'(1) << (RATE_OUT_W - 1)) - 1;
    localparam longint OUT_MIN    = -(longint'(1) << (RATE_OUT_W - 1));

    typedef struct {
        iarc_func_t  func;
        iarc_angle_t roll;
        iarc_angle_t pitch;
        iarc_rate_t  rate_x;
        iarc_rate_t  rate_y;
        iarc_rate_t  rate_z;
    } imu_reading_t;

    typedef struct {
        iarc_angle_out_t roll;
        iarc_angle_out_t pitch;
        iarc_rate_out_t  rate_x;
        iarc_rate_out_t  rate_y;
        iarc_rate_out_t  rate_z;
    } conditioned_t;

    logic clk;
    logic rst_n;

    iarc_cfg_if     cfg_ch ();
    iarc_reading_if reading_ch ();
    iarc_result_if  result_ch ();

    imu_attitude_rate_conditioner_top uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_ch),
        .reading (reading_ch),
        .result  (result_ch)
    );

    // Mirror of the block's registers and state, updated on the accepting edge
    logic [GAIN_W-1:0]     alpha_q    = ALPHA_GAIN_RESET;
    logic [DEADBAND_W-1:0] deadband_q = DEADBAND_RESET;
    int                    roll_ref_m;
    int                    pitch_ref_m;
    longint                rate_acc [3];

    // Conditioned readings still owed by the block, oldest first
    conditioned_t conditioned_due [$];

    int  mismatches;
    int  idle_cycles;
    int  locks_taken;
    int  samples_taken;
    int  results_checked;
    int  register_writes;
    int  hold_request;
    int  longest_hold;
    bit  tx_gaps;
    bit  rx_gaps;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ---------------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------------

    function automatic int clamp_raw_angle(input iarc_angle_t raw);
        int v;
        v = raw;
        if (v > ANGLE_CLAMP)
            v = ANGLE_CLAMP;
        else if (v < -ANGLE_CLAMP)
            v = -ANGLE_CLAMP;
        return v;
    endfunction

    // Relative angle folded back into half a turn, then zeroed inside the deadband
    function automatic iarc_angle_out_t relative_angle(input iarc_angle_t raw, input int ref_a);
        int d;
        int mag;
        d = clamp_raw_angle(raw) - ref_a;
        while (d > HALF_TURN)
            d -= FULL_TURN;
        while (d < -HALF_TURN)
            d += FULL_TURN;
        mag = (d < 0) ? -d : d;
        if (mag < int'(deadband_q))
            d = 0;
        return ANGLE_OUT_W'(d);
    endfunction

    // One low-pass step on one gyro channel; advances the mirrored accumulator
    function automatic iarc_rate_out_t low_pass_rate(input int ch, input iarc_rate_t x);
        longint gain;
        longint xs;
        longint y;
        longint prod;
        longint o;
        gain = alpha_q;
        if (gain > GAIN_ONE)
            gain = GAIN_ONE;
        xs   = longint'(x) * (longint'(1) << FILTER_FRAC_BITS);
        y    = rate_acc[ch];
        prod = gain * (xs - y) + ROUND_HALF;
        y    = y + (prod >>> GAIN_SHIFT);
        if (y > STATE_MAX)
            y = STATE_MAX;
        else if (y < STATE_MIN)
            y = STATE_MIN;
        rate_acc[ch] = y;
        o = y >>> (FILTER_FRAC_BITS - OUT_FRAC_BITS);
        if (o > OUT_MAX)
            o = OUT_MAX;
        else if (o < OUT_MIN)
            o = OUT_MIN;
        return RATE_OUT_W'(o);
    endfunction

    task automatic check_field(input string name, input logic signed [RATE_OUT_W-1:0] want,
                               input logic signed [RATE_OUT_W-1:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // ---------------------------------------------------------------------
    // Monitor: register writes, readings in, conditioned results out, watchdog
    // ---------------------------------------------------------------------

    always @(posedge clk)
    begin : monitor
        conditioned_t want;
        bit           moved;
        moved = 1'b0;

        if (cfg_ch.valid && cfg_ch.ready)
        begin
            moved = 1'b1;
            register_writes++;
            case (cfg_ch.addr)
                CFG_ALPHA_GAIN: alpha_q    = cfg_ch.data[GAIN_W-1:0];
                CFG_DEADBAND:   deadband_q = cfg_ch.data[DEADBAND_W-1:0];
                default: ;
            endcase
        end

        // Check the outgoing result before the incoming reading is predicted
        if (result_ch.valid && result_ch.ready)
        begin
            moved = 1'b1;
            results_checked++;
            if (conditioned_due.size() == 0)
            begin
                $error("result item arrived with nothing outstanding");
                mismatches++;
            end
            else
            begin
                want = conditioned_due.pop_front();
                check_field("roll_angle", want.roll, result_ch.roll_angle);
                check_field("pitch_angle", want.pitch, result_ch.pitch_angle);
                check_field("rate_x_filtered", want.rate_x, result_ch.rate_x_filtered);
                check_field("rate_y_filtered", want.rate_y, result_ch.rate_y_filtered);
                check_field("rate_z_filtered", want.rate_z, result_ch.rate_z_filtered);
            end
        end

        if (reading_ch.valid && reading_ch.ready)
        begin
            moved = 1'b1;
            if (reading_ch.func == FUNC_LOCK)
            begin
                // Lock: latch clamped references, leave the filters alone
                roll_ref_m  = clamp_raw_angle(reading_ch.imu_roll);
                pitch_ref_m = clamp_raw_angle(reading_ch.imu_pitch);
                locks_taken++;
            end
            else
            begin
                want.roll   = relative_angle(reading_ch.imu_roll, roll_ref_m);
                want.pitch  = relative_angle(reading_ch.imu_pitch, pitch_ref_m);
                want.rate_x = low_pass_rate(0, reading_ch.raw_rate_x);
                want.rate_y = low_pass_rate(1, reading_ch.raw_rate_y);
                want.rate_z = low_pass_rate(2, reading_ch.raw_rate_z);
                conditioned_due.push_back(want);
                samples_taken++;
            end
        end

        idle_cycles = moved ? 0 : idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Result-side flow control: random stalls, plus one long hold on request
    // ---------------------------------------------------------------------

    // Mostly short gaps, now and then a long one
    function automatic int gap_len();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(12, 60);
        return $urandom_range(1, 3);
    endfunction

    initial
    begin : result_ready_driver
        int n;
        result_ch.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_request > 0)
            begin
                // Hold off for the requested stretch so the block fills and stalls input
                n = hold_request;
                result_ch.ready <= 1'b0;
                repeat (n) @(posedge clk);
                longest_hold = n;
                hold_request = 0;
            end
            else if (rx_gaps && $urandom_range(0, 3) == 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (gap_len()) @(posedge clk);
            end
            else
            begin
                result_ch.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // ---------------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------------

    function automatic imu_reading_t make_reading(input iarc_func_t f, input int roll,
                                                  input int pitch, input int rx,
                                                  input int ry, input int rz);
        imu_reading_t r;
        r.func   = f;
        r.roll   = ANGLE_W'(roll);
        r.pitch  = ANGLE_W'(pitch);
        r.rate_x = RATE_W'(rx);
        r.rate_y = RATE_W'(ry);
        r.rate_z = RATE_W'(rz);
        return r;
    endfunction

    // Offer one reading and return on the edge that takes it. Valid is left high so
    // that the next call either replaces the item or drops valid in the same step.
    task automatic send_reading(input imu_reading_t r);
        int gap;
        gap = (tx_gaps && $urandom_range(0, 2) == 0) ? gap_len() : 0;
        if (gap > 0)
        begin
            reading_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        reading_ch.valid      <= 1'b1;
        reading_ch.func       <= r.func;
        reading_ch.imu_roll   <= r.roll;
        reading_ch.imu_pitch  <= r.pitch;
        reading_ch.raw_rate_x <= r.rate_x;
        reading_ch.raw_rate_y <= r.rate_y;
        reading_ch.raw_rate_z <= r.rate_z;
        do
            @(posedge clk);
        while (reading_ch.ready !== 1'b1);
    endtask

    // Drop valid, let the monitor log the last item, wait for every owed result,
    // then let any lock item drain
    task automatic settle_block();
        reading_ch.valid <= 1'b0;
        @(posedge clk);
        while (conditioned_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input iarc_cfg_addr_t idx, input int value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.addr  <= idx;
        cfg_ch.data  <= CFG_DATA_W'(value);
        do
            @(posedge clk);
        while (cfg_ch.ready !== 1'b1);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_gain_and_deadband(input int gain, input int band);
        settle_block();
        write_register(CFG_ALPHA_GAIN, gain);
        write_register(CFG_DEADBAND, band);
    endtask

    // Angle biased towards the deadband edge, the half-turn fold and the clamp
    function automatic int rand_angle(input int ref_a);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return int'($urandom_range(0, 2 * ANGLE_CLAMP)) - ANGLE_CLAMP;
            5:       return int'($urandom_range(0, (1 << ANGLE_W) - 1)) + ANGLE_RAW_MIN;
            6:       return ref_a + int'($urandom_range(0, 128)) - 64;
            7:       return ref_a + HALF_TURN + int'($urandom_range(0, 12)) - 6;
            8:       return ref_a - HALF_TURN + int'($urandom_range(0, 12)) - 6;
            default: return $urandom_range(0, 1) ? ANGLE_CLAMP : -ANGLE_CLAMP;
        endcase
    endfunction

    function automatic int rand_rate();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return int'($urandom_range(0, (1 << RATE_W) - 1)) + RATE_MIN;
            5, 6, 7: return int'($urandom_range(0, 1000)) - 500;
            8:       return RATE_MAX;
            default: return RATE_MIN;
        endcase
    endfunction

    function automatic imu_reading_t rand_reading();
        iarc_func_t f;
        f = ($urandom_range(0, 9) == 0) ? FUNC_LOCK : FUNC_SAMPLE;
        return make_reading(f, rand_angle(roll_ref_m), rand_angle(pitch_ref_m),
                            rand_rate(), rand_rate(), rand_rate());
    endfunction

    // ---------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------

    // Reset settings: zero input, and angles either side of the default deadband
    task automatic test_reset_deadband();
        send_reading(make_reading(FUNC_SAMPLE, 0, 0, 0, 0, 0));
        send_reading(make_reading(FUNC_SAMPLE, 44, -44, 900, -900, 1));
        send_reading(make_reading(FUNC_SAMPLE, 45, -45, 900, -900, -1));
    endtask

    // Field extremes, out-of-range angles and a lock carrying rates it must ignore
    task automatic test_clamp_and_lock();
        send_reading(make_reading(FUNC_SAMPLE, ANGLE_RAW_MAX, ANGLE_RAW_MIN,
                                  RATE_MAX, RATE_MIN, 0));
        send_reading(make_reading(FUNC_SAMPLE, ANGLE_CLAMP + 1, -ANGLE_CLAMP - 1,
                                  RATE_MIN, RATE_MAX, RATE_MAX));
        send_reading(make_reading(FUNC_LOCK, ANGLE_RAW_MIN, ANGLE_RAW_MAX,
                                  RATE_MAX, RATE_MAX, RATE_MIN));
        // Full clamp-to-clamp swing needs more than one fold
        send_reading(make_reading(FUNC_SAMPLE, ANGLE_CLAMP, -ANGLE_CLAMP, 0, 0, 0));
        send_reading(make_reading(FUNC_SAMPLE, ANGLE_RAW_MAX, ANGLE_RAW_MIN, 0, 0, 0));
    endtask

    // Half-turn boundary: exactly half a turn stays, one step further folds over
    task automatic test_wrap_boundary();
        send_reading(make_reading(FUNC_LOCK, 0, 0, 0, 0, 0));
        send_reading(make_reading(FUNC_SAMPLE, HALF_TURN, -HALF_TURN, 10, 20, 30));
        send_reading(make_reading(FUNC_SAMPLE, HALF_TURN + 1, -HALF_TURN - 1, 10, 20, 30));
        send_reading(make_reading(FUNC_SAMPLE, FULL_TURN, -FULL_TURN, 10, 20, 30));
    endtask

    // Gain and deadband at their limits and beyond them
    task automatic test_register_extremes();
        set_gain_and_deadband(0, 0);
        send_reading(make_reading(FUNC_SAMPLE, 1, -1, RATE_MAX, RATE_MIN, 1234));
        set_gain_and_deadband(GAIN_ONE, HALF_TURN);
        send_reading(make_reading(FUNC_SAMPLE, HALF_TURN - 1, -HALF_TURN, RATE_MAX,
                                  RATE_MIN, -1234));
        set_gain_and_deadband(GAIN_MAX_CODE, HALF_TURN + 1);
        send_reading(make_reading(FUNC_SAMPLE, HALF_TURN, -HALF_TURN, RATE_MIN,
                                  RATE_MAX, 7));
        set_gain_and_deadband(1, DEADBAND_MAX);
        send_reading(make_reading(FUNC_SAMPLE, HALF_TURN, 17, -3, 3, RATE_MAX));
        set_gain_and_deadband(ALPHA_GAIN_RESET, DEADBAND_RESET);
    endtask

    // Stall the result side for a long stretch while readings keep coming
    task automatic test_backpressure();
        settle_block();
        tx_gaps      = 1'b0;
        rx_gaps      = 1'b0;
        hold_request = LONG_HOLD;
        repeat (40) send_reading(rand_reading());
        settle_block();
    endtask

    // Random phases, each under a fresh gain and deadband and its own idling mix
    task automatic test_random_phases();
        int gain;
        int band;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case ($urandom_range(0, 5))
                0:       gain = 0;
                1:       gain = GAIN_ONE;
                2:       gain = $urandom_range(GAIN_ONE + 1, GAIN_MAX_CODE);
                3:       gain = $urandom_range(1, 16);
                default: gain = $urandom_range(0, GAIN_ONE);
            endcase
            case ($urandom_range(0, 5))
                0:       band = 0;
                1:       band = $urandom_range(0, 64);
                2:       band = $urandom_range(0, HALF_TURN);
                3:       band = HALF_TURN;
                4:       band = $urandom_range(HALF_TURN + 1, DEADBAND_MAX);
                default: band = $urandom_range(20, 200);
            endcase
            set_gain_and_deadband(gain, band);
            // Every fourth phase runs flat out on both sides
            tx_gaps = (phase % 4 != 0) && ($urandom_range(0, 2) != 0);
            rx_gaps = (phase % 4 != 0) && ($urandom_range(0, 2) != 0);
            repeat (PHASE_ITEMS) send_reading(rand_reading());
        end
        settle_block();
    endtask

    // ---------------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------------

    initial
    begin
        rst_n                 <= 1'b0;
        reading_ch.valid      <= 1'b0;
        reading_ch.func       <= FUNC_LOCK;
        reading_ch.imu_roll   <= '0;
        reading_ch.imu_pitch  <= '0;
        reading_ch.raw_rate_x <= '0;
        reading_ch.raw_rate_y <= '0;
        reading_ch.raw_rate_z <= '0;
        cfg_ch.valid          <= 1'b0;
        cfg_ch.addr           <= CFG_ALPHA_GAIN;
        cfg_ch.data           <= '0;
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_deadband();
        test_clamp_and_lock();
        test_wrap_boundary();
        test_register_extremes();
        test_backpressure();
        test_random_phases();

        $display("Covered %0d lock and %0d sample items, %0d results checked, %0d register writes",
                 locks_taken, samples_taken, results_checked, register_writes);
        $display("Longest output hold %0d cycles; %0d field mismatches",
                 longest_hold, mismatches);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
